@@ hw/rtl/crse_pkg.sv @@
package crse_pkg;

   localparam int T_FRAC_BITS = 16;
   localparam int COORD_WIDTH = 32;
   localparam int OUT_WIDTH   = 40;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;
   localparam int MODE_WIDTH  = 2;

   // stream packing
   localparam int PB_LSB      = T_WIDTH;
   localparam int PS_LSB      = PB_LSB + COORD_WIDTH;
   localparam int PE_LSB      = PS_LSB + COORD_WIDTH;
   localparam int PA_LSB      = PE_LSB + COORD_WIDTH;
   localparam int REQ_FIELD_W = PA_LSB + COORD_WIDTH;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

   // datapath widths: each Horner step leaves two guard bits
   localparam int CX_W    = COORD_WIDTH + 8;
   localparam int ACC1_W  = CX_W + T_WIDTH + 1;
   localparam int ACC2_W  = ACC1_W + T_WIDTH + 1;
   localparam int ACC3_W  = ACC2_W + T_WIDTH + 1;
   localparam int LO1_W   = ACC1_W / 2;
   localparam int HI1_W   = ACC1_W - LO1_W;
   localparam int LO2_W   = ACC2_W / 2;
   localparam int HI2_W   = ACC2_W - LO2_W;
   localparam int RND_SH  = 3 * T_FRAC_BITS + 1;
   localparam int RND_W   = ACC3_W - RND_SH;
   localparam int SAT_W   = (RND_W > OUT_WIDTH) ? RND_W : OUT_WIDTH;

   typedef logic [MODE_WIDTH-1:0]         mode_type;
   typedef logic [T_WIDTH-1:0]            param_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CX_W-1:0]        coef_type;

   localparam mode_type MODE_POSITION = 2'd0;
   localparam mode_type MODE_TANGENT  = 2'd1;
   localparam mode_type MODE_ACCEL    = 2'd2;

   localparam param_type T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   localparam logic [ACC3_W-1:0] RND_BIAS =
      {{(ACC3_W - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};

   localparam logic signed [SAT_W-1:0] SAT_MAX =
      {{(SAT_W - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_MIN =
      {{(SAT_W - OUT_WIDTH + 1){1'b1}}, {(OUT_WIDTH - 1){1'b0}}};

endpackage

@@ hw/rtl/catmull_rom_segment_evaluator_unit.sv @@
// Uniform Catmull-Rom segment evaluator, one coordinate axis per transaction.
// Request channel (req_*): tuser carries the mode (position, tangent or
// acceleration); tdata carries local_t (unsigned Q1.16, clamped to one) and
// the four control values in signed Q16.16. Response channel (rsp_*): tdata
// carries the rounded, saturated result in signed Q24.16.
// Throughput is one transaction per cycle while the receiver does not stall:
// the Horner evaluation runs through a 9-stage pipeline (coefficient setup,
// three multiply-accumulate steps each split into a partial-product stage
// and a sum stage, rounding, saturation into the output register).
// All stages advance together while the output register is empty or being
// taken; when rsp_tready is low with a valid response, the whole pipeline
// and req_tready hold, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; no transaction is in flight after
// reset, and data registers are left as they are.
module catmull_rom_segment_evaluator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [16:0] local_t, [48:17] point_before, [80:49] point_start,
   // [112:81] point_end, [144:113] point_after, rest zero
   input  logic [crse_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [crse_pkg::MODE_WIDTH-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [39:0] curve_value
   output logic [crse_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import crse_pkg::*;

   localparam int NUM_STAGES = 9;

   logic                  advance;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   // stage 1: coefficients
   mode_type  mode;
   param_type t_raw;
   param_type t_in;
   coord_type p0, p1, p2, p3;
   coef_type  e0, e1, e2, e3;
   coef_type  a3, a2, a1, a0, d12;
   coef_type  c3_in, c2_in, c1_in, c0_in;
   coef_type  c3_s1_ff, c2_s1_ff, c1_s1_ff, c0_s1_ff;
   param_type t_s1_ff;

   // stage 2: first product
   logic signed [ACC1_W-1:0] p1_in;
   logic signed [ACC1_W-1:0] p1_s2_ff;
   coef_type                 c2_s2_ff, c1_s2_ff, c0_s2_ff;
   param_type                t_s2_ff;

   // stage 3: first sum
   logic [ACC1_W-1:0] acc1_in;
   logic [ACC1_W-1:0] acc1_s3_ff;
   coef_type          c1_s3_ff, c0_s3_ff;
   param_type         t_s3_ff;

   // stage 4: second partial products
   logic [LO1_W+T_WIDTH-1:0]          pl1_in;
   logic signed [HI1_W+T_WIDTH:0]     ph1_in;
   logic [LO1_W+T_WIDTH-1:0]          pl1_s4_ff;
   logic signed [HI1_W+T_WIDTH:0]     ph1_s4_ff;
   coef_type                          c1_s4_ff, c0_s4_ff;
   param_type                         t_s4_ff;

   // stage 5: second sum
   logic [ACC2_W-1:0] acc2_in;
   logic [ACC2_W-1:0] acc2_s5_ff;
   coef_type          c0_s5_ff;
   param_type         t_s5_ff;

   // stage 6: third partial products
   logic [LO2_W+T_WIDTH-1:0]      pl2_in;
   logic signed [HI2_W+T_WIDTH:0] ph2_in;
   logic [LO2_W+T_WIDTH-1:0]      pl2_s6_ff;
   logic signed [HI2_W+T_WIDTH:0] ph2_s6_ff;
   coef_type                      c0_s6_ff;

   // stage 7: third sum
   logic [ACC3_W-1:0] acc3_in;
   logic [ACC3_W-1:0] acc3_s7_ff;

   // stage 8: round
   logic [ACC3_W-1:0] rsum;
   logic [RND_W-1:0]  rnd_in;
   logic [RND_W-1:0]  rnd_s8_ff;

   // stage 9: saturate into output register
   logic signed [SAT_W-1:0] rndx;
   logic [OUT_WIDTH-1:0]    out_in;
   logic [OUT_WIDTH-1:0]    out_s9_ff;

   assign advance    = !valid_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[NUM_STAGES-2:0], req_tvalid};
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = RSP_TDATA_W'(out_s9_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: fold the mode into four Horner coefficients, all scaled to the
   // position's fraction so one rounding shift serves every mode
   always_comb begin
      mode  = req_tuser;
      t_raw = req_tdata[T_WIDTH-1:0];
      p0    = req_tdata[PB_LSB +: COORD_WIDTH];
      p1    = req_tdata[PS_LSB +: COORD_WIDTH];
      p2    = req_tdata[PE_LSB +: COORD_WIDTH];
      p3    = req_tdata[PA_LSB +: COORD_WIDTH];
      t_in  = (t_raw > T_ONE) ? T_ONE : t_raw;
      e0    = {{(CX_W - COORD_WIDTH){p0[COORD_WIDTH-1]}}, p0};
      e1    = {{(CX_W - COORD_WIDTH){p1[COORD_WIDTH-1]}}, p1};
      e2    = {{(CX_W - COORD_WIDTH){p2[COORD_WIDTH-1]}}, p2};
      e3    = {{(CX_W - COORD_WIDTH){p3[COORD_WIDTH-1]}}, p3};
      d12   = e1 - e2;
      a3    = e3 - e0 + d12 + (d12 <<< 1);
      a2    = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      a1    = e2 - e0;
      a0    = e1 <<< 1;
      unique case (mode)
         MODE_POSITION: begin
            c3_in = a3;
            c2_in = a2;
            c1_in = a1;
            c0_in = a0;
         end
         MODE_TANGENT: begin
            c3_in = '0;
            c2_in = a3 + (a3 <<< 1);
            c1_in = a2 <<< 1;
            c0_in = a1;
         end
         MODE_ACCEL: begin
            c3_in = '0;
            c2_in = '0;
            c1_in = (a3 <<< 2) + (a3 <<< 1);
            c0_in = a2 <<< 1;
         end
         default: begin
            c3_in = '0;
            c2_in = '0;
            c1_in = '0;
            c0_in = '0;
         end
      endcase
   end

   always_comb begin
      p1_in   = c3_s1_ff * $signed({1'b0, t_s1_ff});
      acc1_in = p1_s2_ff
              + {{(ACC1_W - T_FRAC_BITS - CX_W){c2_s2_ff[CX_W-1]}}, c2_s2_ff,
                 {T_FRAC_BITS{1'b0}}};
      pl1_in  = acc1_s3_ff[LO1_W-1:0] * t_s3_ff;
      ph1_in  = $signed(acc1_s3_ff[ACC1_W-1:LO1_W]) * $signed({1'b0, t_s3_ff});
      acc2_in = {ph1_s4_ff, {LO1_W{1'b0}}}
              + {{(ACC2_W - LO1_W - T_WIDTH){1'b0}}, pl1_s4_ff}
              + {{(ACC2_W - 2 * T_FRAC_BITS - CX_W){c1_s4_ff[CX_W-1]}}, c1_s4_ff,
                 {(2 * T_FRAC_BITS){1'b0}}};
      pl2_in  = acc2_s5_ff[LO2_W-1:0] * t_s5_ff;
      ph2_in  = $signed(acc2_s5_ff[ACC2_W-1:LO2_W]) * $signed({1'b0, t_s5_ff});
      acc3_in = {ph2_s6_ff, {LO2_W{1'b0}}}
              + {{(ACC3_W - LO2_W - T_WIDTH){1'b0}}, pl2_s6_ff}
              + {{(ACC3_W - 3 * T_FRAC_BITS - CX_W){c0_s6_ff[CX_W-1]}}, c0_s6_ff,
                 {(3 * T_FRAC_BITS){1'b0}}};
      // round half up, then drop the fraction
      rsum    = acc3_s7_ff + RND_BIAS;
      rnd_in  = rsum[ACC3_W-1:RND_SH];
      rndx    = SAT_W'($signed(rnd_s8_ff));
      priority if (rndx > SAT_MAX) begin
         out_in = SAT_MAX[OUT_WIDTH-1:0];
      end else if (rndx < SAT_MIN) begin
         out_in = SAT_MIN[OUT_WIDTH-1:0];
      end else begin
         out_in = rndx[OUT_WIDTH-1:0];
      end
   end

   // datapath: hold everything while the output is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         c3_s1_ff   <= c3_in;
         c2_s1_ff   <= c2_in;
         c1_s1_ff   <= c1_in;
         c0_s1_ff   <= c0_in;
         t_s1_ff    <= t_in;

         p1_s2_ff   <= p1_in;
         c2_s2_ff   <= c2_s1_ff;
         c1_s2_ff   <= c1_s1_ff;
         c0_s2_ff   <= c0_s1_ff;
         t_s2_ff    <= t_s1_ff;

         acc1_s3_ff <= acc1_in;
         c1_s3_ff   <= c1_s2_ff;
         c0_s3_ff   <= c0_s2_ff;
         t_s3_ff    <= t_s2_ff;

         pl1_s4_ff  <= pl1_in;
         ph1_s4_ff  <= ph1_in;
         c1_s4_ff   <= c1_s3_ff;
         c0_s4_ff   <= c0_s3_ff;
         t_s4_ff    <= t_s3_ff;

         acc2_s5_ff <= acc2_in;
         c0_s5_ff   <= c0_s4_ff;
         t_s5_ff    <= t_s4_ff;

         pl2_s6_ff  <= pl2_in;
         ph2_s6_ff  <= ph2_in;
         c0_s6_ff   <= c0_s5_ff;

         acc3_s7_ff <= acc3_in;
         rnd_s8_ff  <= rnd_in;
         out_s9_ff  <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   a_shift_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff == $past({valid_ff[NUM_STAGES-2:0], req_tvalid}))
      else $error("pipeline valid bits did not shift by one stage");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(valid_ff[NUM_STAGES-2]))
      else $error("response appeared without a transaction in the round stage");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while the response is stalled");
`endif

endmodule
